>>> hdl/reb_pkg.sv
`timescale 1ns / 1ps
package reb_pkg;

  localparam int ROWS        = 120;
  localparam int COLS        = 188;
  localparam int MAX_POINTS  = 100;
  localparam int FRAME_DEPTH = ROWS * COLS;
  localparam int FA_W        = $clog2(FRAME_DEPTH);
  localparam int PTS_DEPTH   = 2 * MAX_POINTS;
  localparam int PA_W        = $clog2(PTS_DEPTH);
  localparam int CNT_W       = 7;
  localparam int ROW_W       = 7;
  localparam int COL_W       = 8;
  localparam int SR_W        = 9;
  localparam int SC_W        = 10;
  localparam int SUM_W       = 14;
  localparam int RCP_W       = 21;
  localparam int RCP_SH      = 20;
  localparam int PROD_W      = SUM_W + RCP_W;
  localparam int GRAD_W      = 11;
  localparam int THR_W       = 10;
  localparam int PIX_W       = 9;
  localparam int PT_W        = ROW_W + COL_W;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_WIN_HALF = 2'd0;
  localparam logic [1:0] CFG_EDGE_THR = 2'd1;
  localparam logic [1:0] CFG_CLIP     = 2'd2;

  typedef struct packed {
    logic [1:0] win_half;
    logic [8:0] edge_thr;
    logic [7:0] clip;
  } cfg_t;

  typedef struct packed {
    logic             left_found;
    logic             right_found;
    logic [ROW_W-1:0] left_start_row;
    logic [COL_W-1:0] left_start_col;
    logic [ROW_W-1:0] right_start_row;
    logic [COL_W-1:0] right_start_col;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] point_col;
  } res_t;

  typedef struct packed {
    logic            we;
    logic            re;
    logic [FA_W-1:0] addr;
    logic [PIX_W-1:0] wdata;
  } frame_req_t;

  typedef struct packed {
    logic            we;
    logic            re;
    logic [PA_W-1:0] addr;
    logic [PT_W-1:0] wdata;
  } pts_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_WAIT, ST_FIN, ST_FETCH, ST_FWAIT,
    ST_S_INIT, ST_S_ROW, ST_S_GRAD,
    ST_T_INIT, ST_T_CHECK, ST_T_OUTC, ST_T_WIN, ST_T_DIV, ST_T_THR, ST_T_FV, ST_T_DV
  } st_t;

  function automatic logic [RCP_W-1:0] recip(input logic [1:0] h);
    case (h)
      2'd0:    recip = RCP_W'(1 << RCP_SH);
      2'd1:    recip = RCP_W'(116509);
      2'd2:    recip = RCP_W'(41944);
      default: recip = RCP_W'(21400);
    endcase
  endfunction

  function automatic logic signed [1:0] stp_row(input logic [1:0] d);
    case (d)
      2'd0:    stp_row = -2'sd1;
      2'd2:    stp_row = 2'sd1;
      default: stp_row = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] stp_col(input logic [1:0] d);
    case (d)
      2'd1:    stp_col = 2'sd1;
      2'd3:    stp_col = -2'sd1;
      default: stp_col = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dg_row(input logic sd, input logic [1:0] d);
    if (!sd) dg_row = (d[1]) ? 2'sd1 : -2'sd1;
    else     dg_row = (d == 2'd0 || d == 2'd3) ? -2'sd1 : 2'sd1;
  endfunction

  function automatic logic signed [1:0] dg_col(input logic sd, input logic [1:0] d);
    if (!sd) dg_col = (d == 2'd0 || d == 2'd3) ? -2'sd1 : 2'sd1;
    else     dg_col = (d[1]) ? -2'sd1 : 2'sd1;
  endfunction

endpackage

>>> hdl/reb_ram.sv
`timescale 1ns / 1ps
module reb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/reb_seq.sv
`timescale 1ns / 1ps
module reb_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  reb_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [6:0]           in_pix_row,
  input  logic [7:0]           in_pix_col,
  input  logic [7:0]           in_pix_value,
  input  logic                 in_outside_view,
  input  logic                 in_side,
  input  logic [6:0]           in_point_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output reb_pkg::res_t        out_res,
  output reb_pkg::frame_req_t  fr_req,
  input  logic [reb_pkg::PIX_W-1:0] fr_rdata,
  output reb_pkg::pts_req_t    pt_req,
  input  logic [reb_pkg::PT_W-1:0]  pt_rdata
);
  import reb_pkg::*;

  st_t st_r, st_nxt, ret_r, ret_nxt;
  logic side_r, side_nxt;
  logic signed [SR_W-1:0] y_r, y_nxt, req_row_r, req_row_nxt;
  logic signed [SC_W-1:0] x_r, x_nxt, req_col_r, req_col_nxt;
  logic [2:0] k_r, k_nxt;
  logic signed [GRAD_W-1:0] g_r, g_nxt;
  logic [7:0] pix_val_r, pix_val_nxt;
  logic pix_out_r, pix_out_nxt;
  logic [1:0] found_r, found_nxt;
  logic [ROW_W-1:0] srow_r [2];
  logic [ROW_W-1:0] srow_nxt [2];
  logic [COL_W-1:0] scol_r [2];
  logic [COL_W-1:0] scol_nxt [2];
  logic [CNT_W-1:0] cnt_r [2];
  logic [CNT_W-1:0] cnt_nxt [2];
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [2:0] turn_r, turn_nxt;
  logic signed [2:0] wy_r, wy_nxt, wx_r, wx_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [THR_W-1:0] thr_r, thr_nxt;
  logic rd_ok_r, rd_ok_nxt;
  logic [ROW_W-1:0] prow_r, prow_nxt;
  logic [COL_W-1:0] pcol_r, pcol_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;

  logic signed [SC_W-1:0] h_s;
  logic signed [2:0] h3;
  logic signed [2:0] off0, offk;
  logic signed [GRAD_W-1:0] pix_g, th_g, g_sum;
  logic signed [THR_W-1:0] pix_t;
  logic in_bounds, trace_ok, hit, sdone, tdone;
  logic [FA_W-1:0] fetch_addr, load_addr;
  logic signed [SR_W-1:0] ny;
  logic signed [SC_W-1:0] nx;

  assign h_s   = $signed({8'b0, cfg.win_half});
  assign h3    = $signed({1'b0, cfg.win_half});
  assign pix_g = $signed({3'b0, pix_val_r});
  assign pix_t = $signed({2'b0, pix_val_r});
  assign th_g  = $signed({2'b0, cfg.edge_thr});
  assign off0  = side_r ? 3'sd3 : -3'sd3;

  always_comb begin
    case (k_r)
      3'd0:    offk = 3'sd2;
      3'd1:    offk = 3'sd1;
      3'd2:    offk = -3'sd2;
      default: offk = -3'sd1;
    endcase
  end

  assign in_bounds = (req_row_r >= 0) && (req_row_r < ROWS) &&
                     (req_col_r >= 0) && (req_col_r < COLS);
  assign fetch_addr = FA_W'(req_row_r[7:0]) * FA_W'(COLS) + FA_W'(req_col_r[7:0]);
  assign load_addr  = FA_W'(in_pix_row) * FA_W'(COLS) + FA_W'(in_pix_col);

  assign trace_ok = (step_r < CNT_W'(MAX_POINTS)) && (turn_r < 3'd4) &&
                    (h_s + 1 < x_r) && (x_r < COLS - 2 - h_s) &&
                    (y_r > 6) && (y_r < ROWS - 1 - h_s);

  assign g_sum = (k_r < 3'd3) ? g_r + pix_g : g_r - pix_g;
  assign hit   = side_r ? (g_sum < -th_g) : (g_sum > th_g);

  always_comb begin
    if (pix_t < thr_r) begin
      ny = y_r + SR_W'(stp_row(dir_r));
      nx = x_r + SC_W'(stp_col(dir_r));
    end else begin
      ny = y_r + SR_W'(dg_row(side_r, dir_r));
      nx = x_r + SC_W'(dg_col(side_r, dir_r));
    end
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    st_nxt      = st_r;
    ret_nxt     = ret_r;
    side_nxt    = side_r;
    y_nxt       = y_r;
    x_nxt       = x_r;
    req_row_nxt = req_row_r;
    req_col_nxt = req_col_r;
    k_nxt       = k_r;
    g_nxt       = g_r;
    pix_val_nxt = pix_val_r;
    pix_out_nxt = pix_out_r;
    found_nxt   = found_r;
    srow_nxt    = srow_r;
    scol_nxt    = scol_r;
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    turn_nxt    = turn_r;
    wy_nxt      = wy_r;
    wx_nxt      = wx_r;
    sum_nxt     = sum_r;
    prod_nxt    = prod_r;
    thr_nxt     = thr_r;
    rd_ok_nxt   = rd_ok_r;
    prow_nxt    = prow_r;
    pcol_nxt    = pcol_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sdone       = 1'b0;
    tdone       = 1'b0;
    fr_req      = '0;
    pt_req      = '0;

    unique case (st_r)
      ST_IDLE: begin
        fr_req.addr = load_addr;
        if (in_valid) begin
          unique case (in_kind)
            KIND_LOAD: begin
              fr_req.we    = (in_pix_row < ROWS) && (in_pix_col < COLS);
              fr_req.wdata = {in_outside_view, in_pix_value};
            end
            KIND_RUN: begin
              found_nxt = '0;
              srow_nxt  = '{default: '0};
              scol_nxt  = '{default: '0};
              prow_nxt  = '0;
              pcol_nxt  = '0;
              side_nxt  = 1'b0;
              st_nxt    = ST_S_INIT;
            end
            KIND_READ: begin
              pt_req.re = in_point_index < cnt_r[in_side];
              pt_req.addr = in_side ? PA_W'(MAX_POINTS) + PA_W'(in_point_index)
                                    : PA_W'(in_point_index);
              rd_ok_nxt = in_point_index < cnt_r[in_side];
              st_nxt    = ST_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        prow_nxt = rd_ok_r ? pt_rdata[ROW_W-1:0] : '0;
        pcol_nxt = rd_ok_r ? pt_rdata[PT_W-1:ROW_W] : '0;
        st_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.left_found      = found_r[0];
          out_nxt.right_found     = found_r[1];
          out_nxt.left_start_row  = srow_r[0];
          out_nxt.left_start_col  = scol_r[0];
          out_nxt.right_start_row = srow_r[1];
          out_nxt.right_start_col = scol_r[1];
          out_nxt.left_count      = cnt_r[0];
          out_nxt.right_count     = cnt_r[1];
          out_nxt.point_row       = prow_r;
          out_nxt.point_col       = pcol_r;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      ST_FETCH: begin
        fr_req.addr = fetch_addr;
        if (in_bounds) begin
          fr_req.re = 1'b1;
          st_nxt    = ST_FWAIT;
        end else begin
          pix_val_nxt = '0;
          pix_out_nxt = 1'b1;
          st_nxt      = ret_r;
        end
      end
      ST_FWAIT: begin
        pix_out_nxt = fr_rdata[8];
        pix_val_nxt = fr_rdata[8] ? 8'd0 : fr_rdata[7:0];
        st_nxt      = ret_r;
      end
      ST_S_INIT: begin
        y_nxt  = SR_W'(ROWS - 2 - h_s);
        st_nxt = ST_S_ROW;
      end
      ST_S_ROW: begin
        if (y_r > ROWS - 20 - h_s) begin
          x_nxt       = SC_W'(COLS / 2);
          k_nxt       = 3'd0;
          req_row_nxt = y_r;
          req_col_nxt = SC_W'(COLS / 2) + SC_W'(off0);
          ret_nxt     = ST_S_GRAD;
          st_nxt      = ST_FETCH;
        end else begin
          sdone = 1'b1;
        end
      end
      ST_S_GRAD: begin
        if (k_r == 3'd0 && pix_out_r) begin
          y_nxt  = y_r - SR_W'(1);
          st_nxt = ST_S_ROW;
        end else if (k_r == 3'd0) begin
          g_nxt       = '0;
          k_nxt       = 3'd1;
          req_col_nxt = x_r + SC_W'(offk);
          ret_nxt     = ST_S_GRAD;
          st_nxt      = ST_FETCH;
        end else if (k_r != 3'd4) begin
          g_nxt       = g_sum;
          k_nxt       = k_r + 3'd1;
          req_col_nxt = x_r + SC_W'(offk);
          ret_nxt     = ST_S_GRAD;
          st_nxt      = ST_FETCH;
        end else if (hit) begin
          found_nxt[side_r] = 1'b1;
          srow_nxt[side_r]  = y_r[ROW_W-1:0];
          scol_nxt[side_r]  = x_r[COL_W-1:0];
          sdone = 1'b1;
        end else begin
          x_nxt = side_r ? x_r + SC_W'(1) : x_r - SC_W'(1);
          if (side_r ? (x_nxt < COLS - 2) : (x_nxt > 2)) begin
            k_nxt       = 3'd0;
            req_col_nxt = x_nxt + SC_W'(off0);
            ret_nxt     = ST_S_GRAD;
            st_nxt      = ST_FETCH;
          end else begin
            y_nxt  = y_r - SR_W'(1);
            st_nxt = ST_S_ROW;
          end
        end
      end
      ST_T_INIT: begin
        if (found_r[side_r]) begin
          y_nxt    = SR_W'(srow_r[side_r]);
          x_nxt    = SC_W'(scol_r[side_r]);
          step_nxt = '0;
          dir_nxt  = 2'd0;
          turn_nxt = 3'd0;
          st_nxt   = ST_T_CHECK;
        end else begin
          cnt_nxt[side_r] = '0;
          tdone = 1'b1;
        end
      end
      ST_T_CHECK: begin
        if (trace_ok) begin
          k_nxt       = 3'd0;
          req_row_nxt = y_r;
          req_col_nxt = x_r;
          ret_nxt     = ST_T_OUTC;
          st_nxt      = ST_FETCH;
        end else begin
          cnt_nxt[side_r] = step_r;
          tdone = 1'b1;
        end
      end
      ST_T_OUTC: begin
        if (pix_out_r) begin
          cnt_nxt[side_r] = step_r;
          tdone = 1'b1;
        end else if (k_r != 3'd2) begin
          k_nxt       = k_r + 3'd1;
          req_col_nxt = (k_r == 3'd0) ? x_r - SC_W'(2) : x_r + SC_W'(2);
          ret_nxt     = ST_T_OUTC;
          st_nxt      = ST_FETCH;
        end else begin
          sum_nxt     = '0;
          wy_nxt      = -h3;
          wx_nxt      = -h3;
          req_row_nxt = y_r - SR_W'(h3);
          req_col_nxt = x_r - SC_W'(h3);
          ret_nxt     = ST_T_WIN;
          st_nxt      = ST_FETCH;
        end
      end
      ST_T_WIN: begin
        sum_nxt = sum_r + SUM_W'(pix_val_r);
        if (wx_r == h3 && wy_r == h3) begin
          st_nxt = ST_T_DIV;
        end else begin
          if (wx_r == h3) begin
            wx_nxt = -h3;
            wy_nxt = wy_r + 3'sd1;
          end else begin
            wx_nxt = wx_r + 3'sd1;
          end
          req_row_nxt = y_r + SR_W'(wy_nxt);
          req_col_nxt = x_r + SC_W'(wx_nxt);
          ret_nxt     = ST_T_WIN;
          st_nxt      = ST_FETCH;
        end
      end
      ST_T_DIV: begin
        prod_nxt = PROD_W'(sum_r) * PROD_W'(recip(cfg.win_half));
        st_nxt   = ST_T_THR;
      end
      ST_T_THR: begin
        thr_nxt = $signed({2'b0, prod_r[RCP_SH +: 8]}) - $signed({2'b0, cfg.clip});
        req_row_nxt = y_r + SR_W'(stp_row(dir_r));
        req_col_nxt = x_r + SC_W'(stp_col(dir_r));
        ret_nxt     = ST_T_FV;
        st_nxt      = ST_FETCH;
      end
      ST_T_FV: begin
        if (pix_t < thr_r) begin
          dir_nxt  = side_r ? dir_r - 2'd1 : dir_r + 2'd1;
          turn_nxt = turn_r + 3'd1;
          st_nxt   = ST_T_CHECK;
        end else begin
          req_row_nxt = y_r + SR_W'(dg_row(side_r, dir_r));
          req_col_nxt = x_r + SC_W'(dg_col(side_r, dir_r));
          ret_nxt     = ST_T_DV;
          st_nxt      = ST_FETCH;
        end
      end
      ST_T_DV: begin
        y_nxt = ny;
        x_nxt = nx;
        if (!(pix_t < thr_r)) begin
          dir_nxt = side_r ? dir_r + 2'd1 : dir_r - 2'd1;
        end
        pt_req.we    = 1'b1;
        pt_req.addr  = side_r ? PA_W'(MAX_POINTS) + PA_W'(step_r) : PA_W'(step_r);
        pt_req.wdata = {nx[COL_W-1:0], ny[ROW_W-1:0]};
        step_nxt = step_r + 1'b1;
        turn_nxt = 3'd0;
        st_nxt   = ST_T_CHECK;
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (sdone) begin
      side_nxt = ~side_r;
      st_nxt   = side_r ? ST_T_INIT : ST_S_INIT;
    end
    if (tdone) begin
      side_nxt = ~side_r;
      st_nxt   = side_r ? ST_FIN : ST_T_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      found_r     <= '0;
      srow_r      <= '{default: '0};
      scol_r      <= '{default: '0};
      cnt_r       <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      found_r     <= found_nxt;
      srow_r      <= srow_nxt;
      scol_r      <= scol_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r    <= side_nxt;
    y_r       <= y_nxt;
    x_r       <= x_nxt;
    req_row_r <= req_row_nxt;
    req_col_r <= req_col_nxt;
    k_r       <= k_nxt;
    g_r       <= g_nxt;
    pix_val_r <= pix_val_nxt;
    pix_out_r <= pix_out_nxt;
    step_r    <= step_nxt;
    dir_r     <= dir_nxt;
    turn_r    <= turn_nxt;
    wy_r      <= wy_nxt;
    wx_r      <= wx_nxt;
    sum_r     <= sum_nxt;
    prod_r    <= prod_nxt;
    thr_r     <= thr_nxt;
    rd_ok_r   <= rd_ok_nxt;
    prow_r    <= prow_nxt;
    pcol_r    <= pcol_nxt;
    out_r     <= out_nxt;
  end

endmodule

>>> hdl/road_edge_boundary_tracer.sv
`timescale 1ns / 1ps
// Road edge boundary tracer.
// Input stream: in_tuser carries the command kind (load pixel, run, read point);
// in_tdata carries the pixel and read fields. Loads write the frame memory and
// are taken at one beat per cycle while idle; they give no result beat.
// A run searches both start points and traces both boundaries, then returns one
// result beat. Every pixel access goes through the single frame memory port:
// an in-frame pixel passes the fetch and fetch-wait states, an off-frame one
// only the fetch state. A search probe costs five pixel reads; one trace move
// costs ((2*h+1)^2 + 5) reads, with h the window half width. A read passes
// the read-wait and finish states before its result beat is registered.
// in_tready stays low while a run or read is in progress. A finished result sits
// in the output register; loads are still taken while it waits, and a further
// run or read completes its work and then holds until the receiver takes the
// pending beat. Reset clears flags, starts, counts and the output valid and
// sets the configuration registers to their defaults; frame and point memories
// are not cleared and must be written before use.
module road_edge_boundary_tracer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind
  input  logic [31:0] in_tdata,   // pix_row, pix_col, pix_value, outside_view, side, point_index
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_found, right_found, left_start_row, left_start_col, right_start_row,
  // right_start_col, left_count, right_count, point_row, point_col
  output logic [63:0] out_tdata
);
  import reb_pkg::*;

  cfg_t       cfg_r;
  res_t       res;
  frame_req_t fr_req;
  pts_req_t   pt_req;
  logic [PIX_W-1:0] fr_rdata;
  logic [PT_W-1:0]  pt_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_half <= 2'd1;
      cfg_r.edge_thr <= 9'd100;
      cfg_r.clip     <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WIN_HALF: cfg_r.win_half <= cfg_wdata[1:0];
        CFG_EDGE_THR: cfg_r.edge_thr <= cfg_wdata;
        CFG_CLIP:     cfg_r.clip     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  reb_ram #(.DEPTH(FRAME_DEPTH), .WIDTH(PIX_W)) u_frame (
    .clk   (clk),
    .we    (fr_req.we),
    .re    (fr_req.re),
    .addr  (fr_req.addr),
    .wdata (fr_req.wdata),
    .rdata (fr_rdata)
  );

  reb_ram #(.DEPTH(PTS_DEPTH), .WIDTH(PT_W)) u_points (
    .clk   (clk),
    .we    (pt_req.we),
    .re    (pt_req.re),
    .addr  (pt_req.addr),
    .wdata (pt_req.wdata),
    .rdata (pt_rdata)
  );

  reb_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_kind         (in_tuser),
    .in_pix_row      (in_tdata[6:0]),
    .in_pix_col      (in_tdata[14:7]),
    .in_pix_value    (in_tdata[22:15]),
    .in_outside_view (in_tdata[23]),
    .in_side         (in_tdata[24]),
    .in_point_index  (in_tdata[31:25]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_res         (res),
    .fr_req          (fr_req),
    .fr_rdata        (fr_rdata),
    .pt_req          (pt_req),
    .pt_rdata        (pt_rdata)
  );

  assign out_tdata = {3'b0, res.point_col, res.point_row, res.right_count, res.left_count,
                      res.right_start_col, res.right_start_row, res.left_start_col,
                      res.left_start_row, res.right_found, res.left_found};

  a_frame_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(fr_req.we && fr_req.re))
    else $error("frame memory read and write in one cycle");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == KIND_RUN) |=> !in_tready)
    else $error("input taken straight after a run");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.left_count <= CNT_W'(MAX_POINTS) &&
                    res.right_count <= CNT_W'(MAX_POINTS)))
    else $error("point count beyond limit");

  a_pt_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (pt_req.we || pt_req.re) |-> (pt_req.addr < PA_W'(PTS_DEPTH)))
    else $error("point memory address out of range");

endmodule
